FILE: sv/gcd_pkg.sv
// Shared types, fixed-point constants and helpers for the great-circle distance block.
// Depends on nothing; the rad, cell and top-level files import it.
`timescale 1ns / 1ps
`default_nettype none

package gcd_pkg;

    localparam int ANGLE_FRAC_BITS = 30;
    localparam int AF   = ANGLE_FRAC_BITS;
    localparam int CW   = 35;            // CORDIC / angle datapath, signed
    localparam int DW   = 33;            // coordinate differences, signed
    localparam int SQ_R = AF + 1;        // root bits
    localparam int SQ_W = 2 * AF + 2;    // radicand / remainder bits
    localparam int K_W  = 60;            // degree-to-radian factor bits
    localparam int K_LO = 30;            // low partial-product split
    localparam int RCM_W = 30;           // radius in cm
    localparam int DIST_W = 31;

    localparam logic [63:0] PI_Q60         = 64'h3243F6A8885A308D;
    localparam logic [63:0] GAIN_Q62       = 64'd2800459870029452958;
    localparam logic [63:0] DEG7_HALF_TURN = 64'd1800000000;

    localparam logic [63:0] RAD_K =
        ((PI_Q60 / DEG7_HALF_TURN) << 29)
        + (((PI_Q60 % DEG7_HALF_TURN) << 29) / DEG7_HALF_TURN);

    localparam logic signed [CW-1:0] PI_Q   = CW'((PI_Q60 + (64'd1 << 29)) >> 30);
    localparam logic signed [CW-1:0] HP_Q   = CW'((PI_Q60 + (64'd1 << 30)) >> 31);
    localparam logic signed [CW-1:0] GAIN_Q = CW'((GAIN_Q62 + (64'd1 << 31)) >> 32);
    localparam logic signed [CW-1:0] ONE_Q  = CW'(64'd1 << AF);

    localparam logic [RCM_W-1:0]  RADIUS_CM_RESET = RCM_W'(637100400);
    localparam logic [DIST_W-1:0] DIST_MAX        = {DIST_W{1'b1}};

    typedef struct packed {
        logic signed [30:0] own_latitude;
        logic signed [31:0] own_longitude;
        logic signed [30:0] target_latitude;
        logic signed [31:0] target_longitude;
    } gcd_pos_t;

    // atan(2^-idx) in Q30, rounded to nearest
    function automatic logic signed [CW-1:0] atan_q(input int idx);
        logic signed [CW-1:0] v;
        case (idx)
            0: v = CW'(843314857);
            1: v = CW'(497837829);
            2: v = CW'(263043837);
            3: v = CW'(133525159);
            4: v = CW'(67021687);
            5: v = CW'(33543516);
            6: v = CW'(16775851);
            7: v = CW'(8388437);
            8: v = CW'(4194283);
            9: v = CW'(2097149);
            default:
            begin
                if (idx <= AF)
                    v = CW'(64'd1 << (AF - idx));
                else if (idx == AF + 1)
                    v = CW'(1);
                else
                    v = '0;
            end
        endcase
        return v;
    endfunction

    // sign-magnitude Q30 product, magnitude truncated
    function automatic logic signed [CW-1:0] qmul(input logic signed [CW-1:0] a,
                                                 input logic signed [CW-1:0] b);
        logic [31:0] ua;
        logic [31:0] ub;
        logic [63:0] p;
        logic signed [CW-1:0] r;
        ua = a[CW-1] ? 32'(-a) : 32'(a);
        ub = b[CW-1] ? 32'(-b) : 32'(b);
        p  = 64'(ua) * 64'(ub);
        r  = CW'(p >> AF);
        return (a[CW-1] != b[CW-1]) ? -r : r;
    endfunction

endpackage

`default_nettype wire

FILE: sv/gcd_if.sv
// Channel interfaces: position pairs in, distance out, valid/ready handshake.
// Standalone; no package needed.
`timescale 1ns / 1ps
`default_nettype none

interface gcd_in_if;
    logic               valid;
    logic               ready;
    logic signed [30:0] own_latitude;
    logic signed [31:0] own_longitude;
    logic signed [30:0] target_latitude;
    logic signed [31:0] target_longitude;

    modport source (output valid, own_latitude, own_longitude, target_latitude,
                    target_longitude, input ready);
    modport sink   (input valid, own_latitude, own_longitude, target_latitude,
                    target_longitude, output ready);
endinterface

interface gcd_out_if;
    logic        valid;
    logic        ready;
    logic [30:0] distance_cm;

    modport source (output valid, distance_cm, input ready);
    modport sink   (input valid, distance_cm, output ready);
endinterface

`default_nettype wire

FILE: sv/gcd_rad.sv
// Degree (1e-7) to radian conversion with reduction into [-pi/2, pi/2].
// Three register stages; uses gcd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gcd_rad #(
    parameter int EXTRA = 0
) (
    input  logic                          clk,
    input  logic                          en,
    input  logic signed [gcd_pkg::DW-1:0] deg,
    output logic signed [gcd_pkg::CW-1:0] theta,
    output logic                          flip
);
    import gcd_pkg::*;

    localparam int SHIFT = 89 - AF + EXTRA;

    logic [DW-1:0]          mag;
    logic [DW+K_LO-1:0]     plo_next;
    logic [DW+K_LO-1:0]     plo_reg;
    logic [DW-1:0]          mag_reg;
    logic                   neg_reg;
    logic [DW+K_W-K_LO-1:0] phi;
    logic [DW+K_W-1:0]      full;
    logic signed [CW-1:0]   v;
    logic signed [CW-1:0]   theta_next;
    logic signed [CW-1:0]   theta_reg;
    logic signed [CW-1:0]   z_next;
    logic signed [CW-1:0]   z_reg;
    logic                   flip_next;
    logic                   flip_reg;

    always_comb
    begin
        mag      = deg[DW-1] ? DW'(-deg) : DW'(deg);
        plo_next = (DW+K_LO)'(mag) * (DW+K_LO)'(RAD_K[K_LO-1:0]);
        phi      = (DW+K_W-K_LO)'(mag_reg) * (DW+K_W-K_LO)'(RAD_K[K_W-1:K_LO]);
        full     = {phi, K_LO'(0)} + (DW+K_W)'(plo_reg);
        v        = CW'(full >> SHIFT);
        theta_next = neg_reg ? -v : v;
        if (theta_reg > HP_Q)
        begin
            z_next    = theta_reg - PI_Q;
            flip_next = 1'b1;
        end
        else if (theta_reg < -HP_Q)
        begin
            z_next    = theta_reg + PI_Q;
            flip_next = 1'b1;
        end
        else
        begin
            z_next    = theta_reg;
            flip_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_reg   <= mag;
            neg_reg   <= deg[DW-1];
            plo_reg   <= plo_next;
            theta_reg <= theta_next;
            z_reg     <= z_next;
            flip_reg  <= flip_next;
        end
    end

    assign theta = z_reg;
    assign flip  = flip_reg;

endmodule

`default_nettype wire

FILE: sv/gcd_cordic_cell.sv
// One CORDIC micro-rotation, rotation or vectoring mode, registered.
// Uses gcd_pkg for widths and the arctangent table.
`timescale 1ns / 1ps
`default_nettype none

module gcd_cordic_cell #(
    parameter int IDX    = 0,
    parameter bit VECTOR = 1'b0
) (
    input  logic                          clk,
    input  logic                          en,
    input  logic signed [gcd_pkg::CW-1:0] x_i,
    input  logic signed [gcd_pkg::CW-1:0] y_i,
    input  logic signed [gcd_pkg::CW-1:0] z_i,
    output logic signed [gcd_pkg::CW-1:0] x_o,
    output logic signed [gcd_pkg::CW-1:0] y_o,
    output logic signed [gcd_pkg::CW-1:0] z_o
);
    import gcd_pkg::*;

    localparam logic signed [CW-1:0] ANG = atan_q(IDX);

    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic                 cw;
    logic signed [CW-1:0] x_next;
    logic signed [CW-1:0] y_next;
    logic signed [CW-1:0] z_next;
    logic signed [CW-1:0] x_reg;
    logic signed [CW-1:0] y_reg;
    logic signed [CW-1:0] z_reg;

    always_comb
    begin
        dx = y_i >>> IDX;
        dy = x_i >>> IDX;
        // rotation follows z; vectoring drives y towards zero
        cw = VECTOR ? y_i[CW-1] : !z_i[CW-1];
        if (cw)
        begin
            x_next = x_i - dx;
            y_next = y_i + dy;
            z_next = z_i - ANG;
        end
        else
        begin
            x_next = x_i + dx;
            y_next = y_i - dy;
            z_next = z_i + ANG;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign x_o = x_reg;
    assign y_o = y_reg;
    assign z_o = z_reg;

endmodule

`default_nettype wire

FILE: sv/gcd_sqrt_cell.sv
// One bit of a restoring square root (floor), remainder form, registered.
// Uses gcd_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none

module gcd_sqrt_cell #(
    parameter int BIT = 0
) (
    input  logic                      clk,
    input  logic                      en,
    input  logic [gcd_pkg::SQ_W-1:0]  rem_i,
    input  logic [gcd_pkg::SQ_R-1:0]  root_i,
    output logic [gcd_pkg::SQ_W-1:0]  rem_o,
    output logic [gcd_pkg::SQ_R-1:0]  root_o
);
    import gcd_pkg::*;

    logic [SQ_W-1:0] trial;
    logic [SQ_W-1:0] rem_next;
    logic [SQ_R-1:0] root_next;
    logic [SQ_W-1:0] rem_reg;
    logic [SQ_R-1:0] root_reg;

    always_comb
    begin
        // (r + 2^b)^2 - r^2
        trial = (SQ_W'(root_i) << (BIT + 1)) + (SQ_W'(1) << (2 * BIT));
        if (rem_i >= trial)
        begin
            rem_next  = rem_i - trial;
            root_next = root_i | (SQ_R'(1) << BIT);
        end
        else
        begin
            rem_next  = rem_i;
            root_next = root_i;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign rem_o  = rem_reg;
    assign root_o = root_reg;

endmodule

`default_nettype wire

FILE: sv/great_circle_distance.sv
// Top level: haversine great-circle distance, fully pipelined chain of cells.
// Uses gcd_pkg, gcd_if, gcd_rad, gcd_cordic_cell, gcd_sqrt_cell.
`timescale 1ns / 1ps
`default_nettype none

//  channel    dir  handshake      payload
//  position   in   valid/ready    own/target latitude and longitude, 1e-7 deg
//  distance   out  valid/ready    distance_cm, saturated
//  cfg        in   cfg_we         cfg_wdata = earth radius in metres
//
//  One transfer per cycle in, one per cycle out while results are taken.
//  Most of the pipeline lies in the two CORDIC chains and the two 31-bit
//  square-root chains.
//  rst_n clears the valid line and the skid entry, and loads the radius (6371004 m).
//  When a result is not taken the whole chain holds; a one-entry skid still
//  takes one more transfer on position before ready drops.

module great_circle_distance #(
    parameter int CORDIC_STAGES = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [22:0] cfg_wdata,
    gcd_in_if.sink      position,
    gcd_out_if.source   distance
);
    import gcd_pkg::*;

    localparam int N   = CORDIC_STAGES;
    localparam int LAT = 2 * N + 2 * SQ_R + 10;

    // ---------------------------------------------------------------- config
    logic [RCM_W-1:0] radius_cm_reg;
    logic [RCM_W-1:0] radius_cm_next;

    // store radius pre-scaled to centimetres
    assign radius_cm_next = cfg_we ? RCM_W'(RCM_W'(cfg_wdata) * RCM_W'(100)) : radius_cm_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            radius_cm_reg <= RADIUS_CM_RESET;
        else
            radius_cm_reg <= radius_cm_next;
    end

    // ---------------------------------------------------------- flow control
    logic           adv;
    logic           in_fire;
    logic           skid_vld_reg;
    logic           skid_vld_next;
    gcd_pos_t       skid_reg;
    gcd_pos_t       live;
    gcd_pos_t       sel;
    logic           entry_vld;
    logic [LAT-1:0] vld_reg;

    assign adv     = !vld_reg[LAT-1] || distance.ready;
    assign in_fire = position.valid && !skid_vld_reg;
    assign position.ready = !skid_vld_reg;

    assign live.own_latitude     = position.own_latitude;
    assign live.own_longitude    = position.own_longitude;
    assign live.target_latitude  = position.target_latitude;
    assign live.target_longitude = position.target_longitude;

    assign sel       = skid_vld_reg ? skid_reg : live;
    assign entry_vld = skid_vld_reg || in_fire;

    always_comb
    begin
        if (adv)
            skid_vld_next = 1'b0;
        else
            skid_vld_next = skid_vld_reg || in_fire;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_vld_reg <= 1'b0;
            vld_reg      <= '0;
        end
        else
        begin
            skid_vld_reg <= skid_vld_next;
            if (adv)
                vld_reg <= {vld_reg[LAT-2:0], entry_vld};
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && !adv)
            skid_reg <= live;
    end

    // ---------------------------------------------------------------- entry
    // lanes: 0 dlat, 1 dlon (half angles), 2 own lat, 3 target lat
    logic signed [DW-1:0] d_next [4];
    logic signed [DW-1:0] d_reg  [4];

    always_comb
    begin
        d_next[0] = DW'(sel.own_latitude) - DW'(sel.target_latitude);
        d_next[1] = DW'(sel.own_longitude) - DW'(sel.target_longitude);
        d_next[2] = DW'(sel.own_latitude);
        d_next[3] = DW'(sel.target_latitude);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            d_reg <= d_next;
    end

    // --------------------------------------------------- sin/cos CORDIC lanes
    logic signed [CW-1:0] rx [4][N+1];
    logic signed [CW-1:0] ry [4][N+1];
    logic signed [CW-1:0] rz [4][N+1];
    logic                 flip [4];
    logic [N-1:0]         flip_dly_reg [4];

    for (genvar l = 0; l < 4; l++)
    begin : g_lane
        gcd_rad #(.EXTRA((l < 2) ? 1 : 0)) u_rad (
            .clk   (clk),
            .en    (adv),
            .deg   (d_reg[l]),
            .theta (rz[l][0]),
            .flip  (flip[l])
        );

        assign rx[l][0] = GAIN_Q;
        assign ry[l][0] = '0;

        for (genvar k = 0; k < N; k++)
        begin : g_rot
            gcd_cordic_cell #(.IDX(k), .VECTOR(1'b0)) u_cell (
                .clk (clk),
                .en  (adv),
                .x_i (rx[l][k]),
                .y_i (ry[l][k]),
                .z_i (rz[l][k]),
                .x_o (rx[l][k+1]),
                .y_o (ry[l][k+1]),
                .z_o (rz[l][k+1])
            );
        end

        // quadrant fold travels alongside the rotation
        always_ff @(posedge clk)
        begin
            if (adv)
                flip_dly_reg[l] <= {flip_dly_reg[l][N-2:0], flip[l]};
        end
    end

    // ------------------------------------------------------------ haversine
    logic signed [CW-1:0] sa;
    logic signed [CW-1:0] sb;
    logic signed [CW-1:0] c1;
    logic signed [CW-1:0] c2;
    logic signed [CW-1:0] m1_reg;
    logic signed [CW-1:0] m2_reg;
    logic signed [CW-1:0] m3_reg;
    logic signed [CW-1:0] m1d_reg;
    logic signed [CW-1:0] m4_reg;
    logic signed [CW:0]   hsum;
    logic [SQ_R-1:0]      h_next;
    logic [SQ_R-1:0]      h_reg;

    always_comb
    begin
        sa = flip_dly_reg[0][N-1] ? -ry[0][N] : ry[0][N];
        sb = flip_dly_reg[1][N-1] ? -ry[1][N] : ry[1][N];
        c1 = flip_dly_reg[2][N-1] ? -rx[2][N] : rx[2][N];
        c2 = flip_dly_reg[3][N-1] ? -rx[3][N] : rx[3][N];
        // h clamped into [0, 1]
        hsum = (CW+1)'(m1d_reg) + (CW+1)'(m4_reg);
        if (hsum < 0)
            h_next = '0;
        else if (hsum > (CW+1)'(ONE_Q))
            h_next = SQ_R'(ONE_Q);
        else
            h_next = SQ_R'(hsum);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m1_reg  <= qmul(sa, sa);
            m2_reg  <= qmul(c1, c2);
            m3_reg  <= qmul(sb, sb);
            m1d_reg <= m1_reg;
            m4_reg  <= qmul(m2_reg, m3_reg);
            h_reg   <= h_next;
        end
    end

    // ---------------------------------------------------------- sqrt(h)
    logic [SQ_W-1:0] q1_rem  [SQ_R+1];
    logic [SQ_R-1:0] q1_root [SQ_R+1];

    assign q1_rem[0]  = SQ_W'(h_reg) << AF;
    assign q1_root[0] = '0;

    for (genvar k = 0; k < SQ_R; k++)
    begin : g_sq1
        gcd_sqrt_cell #(.BIT(SQ_R - 1 - k)) u_cell (
            .clk    (clk),
            .en     (adv),
            .rem_i  (q1_rem[k]),
            .root_i (q1_root[k]),
            .rem_o  (q1_rem[k+1]),
            .root_o (q1_root[k+1])
        );
    end

    // --------------------------------------------- 1 - s^2 and its root
    logic signed [CW-1:0] s_sq;
    logic signed [CW-1:0] t_diff;
    logic [SQ_R-1:0]      s_reg;
    logic [SQ_R-1:0]      t_reg;
    logic [SQ_R-1:0]      s_dly_reg [SQ_R];

    always_comb
    begin
        s_sq   = qmul(CW'(q1_root[SQ_R]), CW'(q1_root[SQ_R]));
        t_diff = ONE_Q - s_sq;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s_reg <= q1_root[SQ_R];
            t_reg <= t_diff[CW-1] ? '0 : SQ_R'(t_diff);
            s_dly_reg[0] <= s_reg;
            for (int j = 1; j < SQ_R; j++)
                s_dly_reg[j] <= s_dly_reg[j-1];
        end
    end

    logic [SQ_W-1:0] q2_rem  [SQ_R+1];
    logic [SQ_R-1:0] q2_root [SQ_R+1];

    assign q2_rem[0]  = SQ_W'(t_reg) << AF;
    assign q2_root[0] = '0;

    for (genvar k = 0; k < SQ_R; k++)
    begin : g_sq2
        gcd_sqrt_cell #(.BIT(SQ_R - 1 - k)) u_cell (
            .clk    (clk),
            .en     (adv),
            .rem_i  (q2_rem[k]),
            .root_i (q2_root[k]),
            .rem_o  (q2_rem[k+1]),
            .root_o (q2_root[k+1])
        );
    end

    // --------------------------------------------- arcsine, vectoring CORDIC
    logic signed [CW-1:0] vx [N+1];
    logic signed [CW-1:0] vy [N+1];
    logic signed [CW-1:0] vz [N+1];

    assign vx[0] = CW'(q2_root[SQ_R]);
    assign vy[0] = CW'(s_dly_reg[SQ_R-1]);
    assign vz[0] = '0;

    for (genvar k = 0; k < N; k++)
    begin : g_vec
        gcd_cordic_cell #(.IDX(k), .VECTOR(1'b1)) u_cell (
            .clk (clk),
            .en  (adv),
            .x_i (vx[k]),
            .y_i (vy[k]),
            .z_i (vz[k]),
            .x_o (vx[k+1]),
            .y_o (vy[k+1]),
            .z_o (vz[k+1])
        );
    end

    // ------------------------------------------------ scale and saturate
    logic [AF+2:0]             ang;
    logic [AF+2+RCM_W:0]       prod_reg;
    logic [AF+2+RCM_W-AF:0]    dq;
    logic [DIST_W-1:0]         dist_reg;

    always_comb
    begin
        // central angle = 2*z, negative residue clamped
        ang = vz[N][CW-1] ? '0 : ((AF+3)'(vz[N]) << 1);
        dq  = (AF+3+RCM_W-AF)'(prod_reg >> AF);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg <= (AF+3+RCM_W)'(ang) * (AF+3+RCM_W)'(radius_cm_reg);
            dist_reg <= (dq > (AF+3+RCM_W-AF)'(DIST_MAX)) ? DIST_MAX : DIST_W'(dq);
        end
    end

    assign distance.valid       = vld_reg[LAT-1];
    assign distance.distance_cm = dist_reg;

endmodule

`default_nettype wire
